// ===== rtl/hkvt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hkvt_pkg;

	localparam int KEY_W = 31;
	localparam int VAL_W = 31;

	typedef enum logic [1:0] {
		OP_PUT    = 2'd0,
		OP_GET    = 2'd1,
		OP_REMOVE = 2'd2
	} hkvt_op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL,
		ST_SCALE,
		ST_REDUCE,
		ST_READ,
		ST_UPDATE
	} hkvt_state_t;

	typedef struct packed {
		logic load_in;
		logic clear_wr;
		logic update;
	} hkvt_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic out_busy;
	} hkvt_status_t;

endpackage

`default_nettype wire

// ===== rtl/hashed_key_value_table.sv =====
// hashed key-value table: put, get or remove one key per transaction
// input channel in_valid/in_ready carries command, key and value; the
// output channel out_valid/out_ready returns found, read_value and status
// for every transaction, in order
// the bucket is key modulo NUM_BUCKETS, each bucket holds WAYS entries;
// a put of a new key into a full bucket is dropped with status 1
// out_valid rises when the bucket row is written; the next input is taken
// only after that row update, which follows the chain of reciprocal
// multiply, scaling multiply, correction and the registered bucket row
// read ahead of the read-modify-write of that row
// reset: a clearing pass writes every bucket row empty, one row a cycle,
// with in_ready low
// a stalled receiver holds the result in the output register; the next
// transaction may be accepted and runs up to the row update, where it
// waits until the held result is taken
`timescale 1ns / 1ps
`default_nettype none

module hashed_key_value_table #(
	parameter int NUM_BUCKETS = 2048,
	parameter int WAYS        = 4
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [1:0]                 command,
	input  wire logic [hkvt_pkg::KEY_W-1:0] key,
	input  wire logic [hkvt_pkg::VAL_W-1:0] value,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic                            found,
	output logic [hkvt_pkg::VAL_W-1:0]      read_value,
	output logic                            status
);

	hkvt_pkg::hkvt_cmd_t    cmd;
	hkvt_pkg::hkvt_status_t stat;

	hkvt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	hkvt_datapath #(
		.NUM_BUCKETS (NUM_BUCKETS),
		.WAYS        (WAYS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.command    (command),
		.key        (key),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.found      (found),
		.read_value (read_value),
		.status     (status)
	);

endmodule

`default_nettype wire

// ===== rtl/hkvt_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hkvt_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire hkvt_pkg::hkvt_status_t stat,
	output hkvt_pkg::hkvt_cmd_t       cmd
);

	hkvt_pkg::hkvt_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hkvt_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		cmd.load_in  = 1'b0;
		cmd.clear_wr = 1'b0;
		cmd.update   = 1'b0;
		unique case (state_q)
			hkvt_pkg::ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (stat.clear_last) begin
					state_d = hkvt_pkg::ST_IDLE;
				end
			end
			hkvt_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = hkvt_pkg::ST_MUL;
				end
			end
			hkvt_pkg::ST_MUL:    state_d = hkvt_pkg::ST_SCALE;
			hkvt_pkg::ST_SCALE:  state_d = hkvt_pkg::ST_REDUCE;
			hkvt_pkg::ST_REDUCE: state_d = hkvt_pkg::ST_READ;
			hkvt_pkg::ST_READ:   state_d = hkvt_pkg::ST_UPDATE;
			hkvt_pkg::ST_UPDATE: begin
				if (!stat.out_busy) begin
					cmd.update = 1'b1;
					state_d    = hkvt_pkg::ST_IDLE;
				end
			end
			default: state_d = hkvt_pkg::ST_CLEAR;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/hkvt_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hkvt_datapath #(
	parameter int NUM_BUCKETS = 2048,
	parameter int WAYS        = 4
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire hkvt_pkg::hkvt_cmd_t           cmd,
	output hkvt_pkg::hkvt_status_t             stat,
	input  wire logic [1:0]                    command,
	input  wire logic [hkvt_pkg::KEY_W-1:0]    key,
	input  wire logic [hkvt_pkg::VAL_W-1:0]    value,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               found,
	output logic [hkvt_pkg::VAL_W-1:0]         read_value,
	output logic                               status
);

	localparam int KW = hkvt_pkg::KEY_W;
	localparam int VW = hkvt_pkg::VAL_W;
	localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam logic [32:0] RECIP = 33'((64'd1 << 32) / NUM_BUCKETS);
	localparam logic [KW-1:0] NB = KW'(NUM_BUCKETS);
	localparam logic [BW-1:0] LAST_ROW = BW'(NUM_BUCKETS - 1);

	logic [1:0]    cmd_q;
	logic [KW-1:0] key_q;
	logic [VW-1:0] val_q;

	logic [62:0]   prod1_s1;
	logic [KW-1:0] prod2_s2;
	logic [KW-1:0] rem_raw, rem;
	logic [BW-1:0] bucket_q;
	logic [BW-1:0] clr_q;

	logic [WAYS-1:0]         mem_valid [NUM_BUCKETS];
	logic [WAYS-1:0][KW-1:0] mem_key   [NUM_BUCKETS];
	logic [WAYS-1:0][VW-1:0] mem_val   [NUM_BUCKETS];

	logic [WAYS-1:0]         row_valid_q;
	logic [WAYS-1:0][KW-1:0] row_key_q;
	logic [WAYS-1:0][VW-1:0] row_val_q;

	logic [WAYS-1:0]         wr_valid;
	logic [WAYS-1:0][KW-1:0] wr_key;
	logic [WAYS-1:0][VW-1:0] wr_val;
	logic [BW-1:0]           wr_addr;
	logic                    wr_en;

	logic [WAYS-1:0] hit_vec, free_oh;
	logic            present, full;
	logic            found_d, status_d;
	logic [VW-1:0]   rd_d;

	logic            out_valid_q, found_q, status_q;
	logic [VW-1:0]   rd_q;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cmd_q <= command;
			key_q <= key;
			val_q <= value;
		end
	end

	// bucket index by reciprocal multiply, then one correction
	always_ff @(posedge clk) begin
		prod1_s1 <= 63'(key_q) * 63'(RECIP);
		prod2_s2 <= KW'(prod1_s1[62:32] * NB);
		bucket_q <= BW'(rem);
	end

	always_comb begin
		rem_raw = key_q - prod2_s2;
		rem     = (rem_raw >= NB) ? (rem_raw - NB) : rem_raw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear_wr) begin
			clr_q <= clr_q + BW'(1);
		end
	end

	assign stat.clear_last = (clr_q == LAST_ROW);
	assign stat.out_busy   = out_valid_q && !out_ready;

	always_ff @(posedge clk) begin
		row_valid_q <= mem_valid[bucket_q];
		row_key_q   <= mem_key[bucket_q];
		row_val_q   <= mem_val[bucket_q];
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_valid[wr_addr] <= wr_valid;
			mem_key[wr_addr]   <= wr_key;
			mem_val[wr_addr]   <= wr_val;
		end
	end

	always_comb begin
		logic taken;
		taken   = 1'b0;
		rd_d    = '0;
		for (int w = 0; w < WAYS; w++) begin
			hit_vec[w] = row_valid_q[w] && (row_key_q[w] == key_q);
			free_oh[w] = !row_valid_q[w] && !taken;
			taken      = taken || !row_valid_q[w];
			rd_d       = rd_d | (hit_vec[w] ? row_val_q[w] : '0);
		end
		present = |hit_vec;
		full    = &row_valid_q;
	end

	always_comb begin
		wr_valid = row_valid_q;
		wr_key   = row_key_q;
		wr_val   = row_val_q;
		found_d  = 1'b0;
		status_d = 1'b0;
		unique case (cmd_q)
			hkvt_pkg::OP_PUT: begin
				found_d  = present;
				status_d = !present && full;
				for (int w = 0; w < WAYS; w++) begin
					if (present && hit_vec[w]) begin
						wr_val[w] = val_q;
					end else if (!present && free_oh[w]) begin
						wr_valid[w] = 1'b1;
						wr_key[w]   = key_q;
						wr_val[w]   = val_q;
					end
				end
			end
			hkvt_pkg::OP_GET: begin
				found_d = present;
			end
			hkvt_pkg::OP_REMOVE: begin
				found_d = present;
				for (int w = 0; w < WAYS; w++) begin
					if (hit_vec[w]) begin
						wr_valid[w] = 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
		if (cmd.clear_wr) begin
			wr_valid = '0;
			wr_addr  = clr_q;
		end else begin
			wr_addr  = bucket_q;
		end
		wr_en = cmd.clear_wr || cmd.update;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.update) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			found_q  <= found_d;
			status_q <= status_d;
			rd_q     <= (cmd_q == hkvt_pkg::OP_GET) ? rd_d : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign found      = found_q;
	assign read_value = rd_q;
	assign status     = status_q;

endmodule

`default_nettype wire
